>>> sv/assert_macros.svh
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error("lbl");
`define CHK_NEXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error("lbl");
`endif

>>> sv/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256 package
// round constants, initial hash values, helper function and shared types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package sha256_pkg;
    localparam int QDEPTH = 4;
    localparam int QAW = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last_item;
    } t_item;

    typedef logic [31:0] t_word;

    localparam t_word H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam t_word K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic t_word rotr(input t_word v, input int n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction
endpackage

>>> sv/sha256_byte_stream_hasher_unit.sv
// ----------------------------------------------------------------------------
// sha256 byte stream hasher
// byte-wide sha-256 with padding, emitting the digest as four 64-bit words
// ----------------------------------------------------------------------------
// Each accepted item carries one byte and/or the end-of-message mark; items with
// neither are taken and dropped. Items wait in a four-item queue and the back end
// takes one a cycle into its block store while it is idle. A full 64-byte block
// then holds the queue while the back end loads the schedule words, runs the
// rounds and folds the result into the hash words; no byte of the next block is
// taken until that is done. The final item adds one or two padded blocks, each a
// pad step followed by the same load, rounds and fold, before the digest appears.
// The digest waits in an output register while the next message streams in; only
// a second finished digest waits for the first to be taken.
`timescale 1ns / 1ps
module sha256_byte_stream_hasher_unit import sha256_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // data_byte
    input  logic         s_axis_tuser,   // has_byte
    input  logic         s_axis_tlast,   // last_item
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [255:0] m_axis_tdata    // digest_word0..digest_word3
);
    t_item        w_in, w_qi;
    logic         w_qv, w_pop;
    logic [255:0] w_dig;

    assign w_in = '{data_byte: s_axis_tdata, has_byte: s_axis_tuser,
                    last_item: s_axis_tlast};

    sha256_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_axis_tvalid),
        .o_ready(s_axis_tready), .i_item(w_in), .o_q_valid(w_qv),
        .i_q_pop(w_pop), .o_q_item(w_qi));

    sha256_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(w_qv), .o_q_pop(w_pop),
        .i_q_item(w_qi), .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_digest(w_dig));

    assign m_axis_tdata = {w_dig[63:0], w_dig[127:64], w_dig[191:128], w_dig[255:192]};
endmodule

>>> sv/sha256_front.sv
// ----------------------------------------------------------------------------
// sha256 front
// accepts items, drops empty ones and queues the rest for the back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sha256_front import sha256_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_q_valid,
    input  logic  i_q_pop,
    output t_item o_q_item
);
    t_item            r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp, r_rp;
    logic [QAW:0]     r_cnt;
    logic             w_push, w_pop;

    assign o_ready   = (r_cnt != QAW'(0) + (QAW+1)'(QDEPTH)) ? 1'b1 : 1'b0;
    assign w_push    = i_valid && o_ready && (i_item.has_byte || i_item.last_item);
    assign w_pop     = i_q_pop && o_q_valid;
    assign o_q_valid = (r_cnt != '0);
    assign o_q_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QAW+1)'(w_push) - (QAW+1)'(w_pop);
        end
    end
endmodule

>>> sv/sha256_back.sv
// ----------------------------------------------------------------------------
// sha256 back end
// block store, padding sequencer and one-round-per-cycle compression
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sha256_back import sha256_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_q_valid,
    output logic         o_q_pop,
    input  t_item        i_q_item,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [255:0] o_digest
);
    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_ROUND, S_PAD, S_DONE
    } t_state;

    t_state       r_state;
    t_word        r_blk [16];
    logic [5:0]   r_fill;
    logic [63:0]  r_bits;
    t_word        r_h [8];
    t_word        r_v [8];
    t_word        r_w [16];
    logic [5:0]   r_round;
    logic [4:0]   r_ld;
    logic         r_final;
    logic         r_pend_last;
    logic         r_pad2;
    logic         r_out_v;
    logic [255:0] r_dig;

    t_word w_wt, w_s0, w_s1, w_t1, w_t2, w_new;
    t_word w_ldw;
    t_word w_bw;
    t_word w_pad [16];
    logic  w_pad_final;
    logic  w_dig_load;

    always_comb begin
        w_s0  = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        w_s1  = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = r_w[0] + w_s0 + r_w[9] + w_s1;
        w_wt  = r_w[0];
        w_t1  = r_v[7] + (rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25))
              + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + K_TAB[r_round] + w_wt;
        w_t2  = (rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22))
              + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
        w_ldw = r_blk[r_ld[3:0]];

        // big-endian byte lane of the incoming byte
        w_bw = r_blk[r_fill[5:2]];
        unique case (r_fill[1:0])
            2'd0: w_bw[31:24] = i_q_item.data_byte;
            2'd1: w_bw[23:16] = i_q_item.data_byte;
            2'd2: w_bw[15:8]  = i_q_item.data_byte;
            2'd3: w_bw[7:0]   = i_q_item.data_byte;
        endcase

        // marker, zero fill, length; second block when the fill has reached 56
        w_pad_final = !(r_pend_last && (r_fill >= 6'd56));
        for (int w = 0; w < 16; w++) begin
            for (int b = 0; b < 4; b++) begin
                if (6'(4*w+b) > r_fill)
                    w_pad[4'(w)][31-8*b -: 8] = 8'h00;
                else if (6'(4*w+b) == r_fill)
                    w_pad[4'(w)][31-8*b -: 8] = r_pend_last ? 8'h80 : 8'h00;
                else
                    w_pad[4'(w)][31-8*b -: 8] = r_blk[4'(w)][31-8*b -: 8];
            end
        end
        if (w_pad_final) begin
            w_pad[14] = r_bits[63:32];
            w_pad[15] = r_bits[31:0];
        end

        w_dig_load = (r_state == S_DONE) && r_final && (!r_out_v || i_ready);
    end

    assign o_q_pop  = (r_state == S_IDLE);
    assign o_valid  = r_out_v;
    assign o_digest = r_dig;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_bits      <= '0;
            r_out_v     <= 1'b0;
            r_final     <= 1'b0;
            r_pend_last <= 1'b0;
            r_pad2      <= 1'b0;
            r_round     <= '0;
            r_ld        <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= H_INIT[i];
        end else begin
            if (w_dig_load) r_out_v <= 1'b1;
            else if (i_ready) r_out_v <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (o_q_pop && i_q_valid) begin
                        r_pend_last <= i_q_item.last_item;
                        if (i_q_item.has_byte) begin
                            r_blk[r_fill[5:2]] <= w_bw;
                            r_fill <= r_fill + 6'd1;
                            r_bits <= r_bits + 64'd8;
                            if (r_fill == 6'd63) begin
                                r_final <= 1'b0;
                                r_ld    <= '0;
                                r_state <= S_LOAD;
                            end else if (i_q_item.last_item) begin
                                r_state <= S_PAD;
                            end
                        end else begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_pend_last <= 1'b0;
                    for (int w = 0; w < 16; w++) r_blk[4'(w)] <= w_pad[4'(w)];
                    r_final <= w_pad_final;
                    r_pad2  <= !w_pad_final;
                    r_fill  <= '0;
                    r_ld    <= '0;
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_w[r_ld[3:0]] <= w_ldw;
                    r_ld <= r_ld + 5'd1;
                    if (r_ld == 5'd15) begin
                        for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                        r_round <= '0;
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= w_new;
                    r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + w_t1;
                    r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                    r_v[0] <= w_t1 + w_t2;
                    r_round <= r_round + 6'd1;
                    if (r_round == 6'd63) r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_final) begin
                        for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                        r_state <= (r_pend_last || r_pad2) ? S_PAD : S_IDLE;
                    end else if (w_dig_load) begin
                        for (int i = 0; i < 8; i++)
                            r_dig[255-32*i -: 32] <= r_h[i] + r_v[i];
                        for (int i = 0; i < 8; i++) r_h[i] <= H_INIT[i];
                        r_bits  <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> sv/sha256_checker.sv
// ----------------------------------------------------------------------------
// sha256 checker
// port-level properties of the hasher
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sha256_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [255:0] m_axis_tdata
);
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `CHK_NEXT(a_data_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    `CHK_IMPL(a_idle_after_rst, i_clk, i_rst_n, $rose(i_rst_n), !m_axis_tvalid)
    `CHK_IMPL(a_rdy_after_rst, i_clk, i_rst_n, $rose(i_rst_n), s_axis_tready)
endmodule

bind sha256_byte_stream_hasher_unit sha256_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata));
